// ===== hdl/truss_member_stiffness_assert.svh =====
// Assertion macros for the truss member stiffness block.
// Uses the clk and rst_n names of the module that includes it.
`ifndef TRUSS_MEMBER_STIFFNESS_ASSERT_SVH
`define TRUSS_MEMBER_STIFFNESS_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TMS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define TMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tms_pkg.sv =====
// Types and constants of the truss member stiffness block.
// No dependencies.
package tms_pkg;

    localparam int COORD_W  = 32;
    localparam int NODE_W   = 11;
    localparam int PROP_W   = 32;
    localparam int GIDX_W   = 22;
    localparam int STIFF_W  = 64;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_LEN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_NODE = 2'd2;

    localparam logic [3:0] LAST_ENTRY = 4'd15;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic [NODE_W-1:0]         start_node;
        logic [NODE_W-1:0]         end_node;
        logic [PROP_W-1:0]         modulus;
        logic [PROP_W-1:0]         section_area;
    } member_t;

    // per-entry tag carried down the pipe
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [GIDX_W-1:0]   gidx;
        logic                negate;
        logic                last;
    } meta_t;

    typedef struct packed {
        meta_t       meta;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] modulus;
        logic [31:0] area;
        logic [31:0] mag_r;
        logic [31:0] mag_c;
    } front_t;

    typedef struct packed {
        meta_t       meta;
        logic [63:0] sqx;
        logic [63:0] sqy;
        logic [63:0] ea;
        logic [63:0] mm;
    } prod_t;

    typedef struct packed {
        meta_t       meta;
        logic [64:0] l2;
        logic [63:0] pp_ll;
        logic [63:0] pp_lh;
        logic [63:0] pp_hl;
        logic [63:0] pp_hh;
    } part_t;

    typedef struct packed {
        meta_t        meta;
        logic [64:0]  l2;
        logic [143:0] num;
        logic [32:0]  root;
        logic [65:0]  sqr;
    } root_t;

    typedef struct packed {
        meta_t        meta;
        logic [143:0] num;
        logic [64:0]  p_lo;
        logic [65:0]  p_hi;
    } denp_t;

    typedef struct packed {
        meta_t        meta;
        logic [143:0] num;
        logic [97:0]  den;
    } den_t;

    typedef struct packed {
        meta_t        meta;
        logic         big;
        logic [143:0] rem;
        logic [62:0]  quo;
        logic [97:0]  den;
    } div_t;

endpackage

// ===== hdl/tms_if.sv =====
// Valid/ready channels of the truss member stiffness block.
// Depends on tms_pkg for field widths.
interface tms_member_if;
    import tms_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic [NODE_W-1:0]         start_node;
    logic [NODE_W-1:0]         end_node;
    logic [PROP_W-1:0]         modulus;
    logic [PROP_W-1:0]         section_area;

    modport source (output valid, start_x, start_y, end_x, end_y, start_node, end_node,
                    modulus, section_area, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, start_node, end_node,
                    modulus, section_area, output ready);
endinterface

interface tms_entry_if;
    import tms_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [GIDX_W-1:0]         global_index;
    logic signed [STIFF_W-1:0] stiffness;
    logic [STATUS_W-1:0]       status;
    logic                      last;

    modport source (output valid, global_index, stiffness, status, last, input ready);
    modport sink   (input valid, global_index, stiffness, status, last, output ready);
endinterface

// ===== hdl/truss_member_stiffness.sv =====
// Channel  | Dir | Carries
// member   | in  | end points, node numbers, modulus, area of one member
// result   | out | global_index, stiffness, status, last (16 per member)
//
// Each member sits in the entry sequencer until all 16 of its entries
// have issued; the sequencer issues one entry per cycle while the result
// channel is not stalled, into a 104-stage pipe (multipliers, a
// one-bit-per-stage square root, a one-bit-per-stage divider).
// Reset clears valid bits, sequencer and num_nodes (to 2).
// A stalled result holds the whole pipe; nothing is dropped or repeated.
// Depends on tms_pkg, tms_if.sv and truss_member_stiffness_assert.svh.
module truss_member_stiffness #(
    parameter int unsigned MAX_NODES = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [tms_pkg::NODE_W-1:0] cfg_wr_data,
    tms_member_if.sink                 member,
    tms_entry_if.source                result
);
    import tms_pkg::*;

    localparam int SQ_STAGES  = 33;
    localparam int DIV_STAGES = 63;

    logic [NODE_W-1:0] num_nodes_reg;
    logic [NODE_W-1:0] nn;

    member_t    mbr_reg;
    logic       mbr_valid_reg;
    logic [3:0] cnt_reg;

    logic       adv;
    logic       take;

    front_t     s1_next, s1_reg;
    prod_t      s2_reg;
    part_t      s3_reg;
    root_t      sq_reg [SQ_STAGES+1];
    denp_t      d1_reg;
    den_t       d2_reg;
    div_t       dv_reg [DIV_STAGES+1];
    logic       v1_reg, v2_reg, v3_reg, vd1_reg, vd2_reg;
    logic [SQ_STAGES:0]  sqv_reg;
    logic [DIV_STAGES:0] dvv_reg;

    logic                out_valid_reg;
    logic [GIDX_W-1:0]   out_gidx_reg;
    logic [STIFF_W-1:0]  out_stiff_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_last_reg;

    // ---------------- config ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            num_nodes_reg <= 11'd2;
        else if (cfg_wr_en)
            num_nodes_reg <= cfg_wr_data;
    end

    assign nn = (32'(num_nodes_reg) > MAX_NODES) ? NODE_W'(MAX_NODES) : num_nodes_reg;

    // ---------------- entry sequencer ----------------
    assign adv          = !out_valid_reg || result.ready;
    assign member.ready = !mbr_valid_reg || (adv && cnt_reg == LAST_ENTRY);
    assign take         = member.valid && member.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbr_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else if (take)
        begin
            mbr_valid_reg <= 1'b1;
            cnt_reg       <= '0;
        end
        else if (mbr_valid_reg && adv)
        begin
            cnt_reg <= cnt_reg + 4'd1;
            if (cnt_reg == LAST_ENTRY)
                mbr_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mbr_reg.start_x      <= member.start_x;
            mbr_reg.start_y      <= member.start_y;
            mbr_reg.end_x        <= member.end_x;
            mbr_reg.end_y        <= member.end_y;
            mbr_reg.start_node   <= member.start_node;
            mbr_reg.end_node     <= member.end_node;
            mbr_reg.modulus      <= member.modulus;
            mbr_reg.section_area <= member.section_area;
        end
    end

    // ---------------- stage 1: deltas, index, sign ----------------
    function automatic logic dir_neg(logic [1:0] k, logic signed [32:0] dx,
                                     logic signed [32:0] dy);
        logic d;
        d = 1'b0;
        unique case (k)
            2'd0: d = dx < 0;
            2'd1: d = dy < 0;
            2'd2: d = dx > 0;
            2'd3: d = dy > 0;
            default: d = 1'b0;
        endcase
        return d;
    endfunction

    always_comb
    begin
        logic signed [32:0] dx, dy;
        logic [1:0]         row, col;
        logic [NODE_W-1:0]  node_r, node_c;
        logic [11:0]        dof_r, dof_c;
        logic [11:0]        stride;
        logic               bad;

        dx     = 33'(mbr_reg.end_x) - 33'(mbr_reg.start_x);
        dy     = 33'(mbr_reg.end_y) - 33'(mbr_reg.start_y);
        row    = cnt_reg[3:2];
        col    = cnt_reg[1:0];
        node_r = row[1] ? mbr_reg.end_node : mbr_reg.start_node;
        node_c = col[1] ? mbr_reg.end_node : mbr_reg.start_node;
        dof_r  = {node_r - 11'd1, row[0]};
        dof_c  = {node_c - 11'd1, col[0]};
        stride = {nn, 1'b0};
        bad    = mbr_reg.start_node == '0 || mbr_reg.start_node > nn ||
                 mbr_reg.end_node == '0 || mbr_reg.end_node > nn;

        s1_next.ax = 32'(dx < 0 ? -dx : dx);
        s1_next.ay = 32'(dy < 0 ? -dy : dy);
        priority if (bad)
            s1_next.meta.status = ST_BAD_NODE;
        else if (dx == 0 && dy == 0)
            s1_next.meta.status = ST_ZERO_LEN;
        else
            s1_next.meta.status = ST_OK;
        s1_next.meta.gidx   = GIDX_W'(24'(dof_r) * 24'(stride) + 24'(dof_c));
        s1_next.meta.negate = dir_neg(row, dx, dy) ^ dir_neg(col, dx, dy);
        s1_next.meta.last   = cnt_reg == LAST_ENTRY;
        s1_next.modulus     = mbr_reg.modulus;
        s1_next.area        = mbr_reg.section_area;
        s1_next.mag_r       = row[0] ? s1_next.ay : s1_next.ax;
        s1_next.mag_c       = col[0] ? s1_next.ay : s1_next.ax;
    end

    // ---------------- step functions ----------------
    // tries root bit b: (r + 2^b)^2 = r^2 + r*2^(b+1) + 2^(2b)
    function automatic root_t sqrt_step(root_t s, int b);
        root_t       o;
        logic [65:0] c_sq;
        o    = s;
        c_sq = s.sqr + (66'(s.root) << (b + 1)) + (66'(1) << (2 * b));
        if (c_sq <= 66'(s.l2))
        begin
            o.root = s.root | (33'(1) << b);
            o.sqr  = c_sq;
        end
        return o;
    endfunction

    function automatic div_t div_step(div_t s, int b);
        div_t         o;
        logic [160:0] cand;
        o    = s;
        cand = 161'(s.den) << b;
        if (161'(s.rem) >= cand)
        begin
            o.rem    = s.rem - cand[143:0];
            o.quo[b] = 1'b1;
        end
        return o;
    endfunction

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;

            s2_reg.meta <= s1_reg.meta;
            s2_reg.sqx  <= 64'(s1_reg.ax) * 64'(s1_reg.ax);
            s2_reg.sqy  <= 64'(s1_reg.ay) * 64'(s1_reg.ay);
            s2_reg.ea   <= 64'(s1_reg.modulus) * 64'(s1_reg.area);
            s2_reg.mm   <= 64'(s1_reg.mag_r) * 64'(s1_reg.mag_c);

            s3_reg.meta  <= s2_reg.meta;
            s3_reg.l2    <= 65'(s2_reg.sqx) + 65'(s2_reg.sqy);
            s3_reg.pp_ll <= 64'(s2_reg.ea[31:0])  * 64'(s2_reg.mm[31:0]);
            s3_reg.pp_lh <= 64'(s2_reg.ea[31:0])  * 64'(s2_reg.mm[63:32]);
            s3_reg.pp_hl <= 64'(s2_reg.ea[63:32]) * 64'(s2_reg.mm[31:0]);
            s3_reg.pp_hh <= 64'(s2_reg.ea[63:32]) * 64'(s2_reg.mm[63:32]);

            // E*A*|d_r|*|d_c| in Q.16
            sq_reg[0].meta <= s3_reg.meta;
            sq_reg[0].l2   <= s3_reg.l2;
            sq_reg[0].num  <= 144'({s3_reg.pp_hh, 64'd0} + (128'(s3_reg.pp_lh) << 32)
                              + (128'(s3_reg.pp_hl) << 32) + 128'(s3_reg.pp_ll)) << 16;
            sq_reg[0].root <= '0;
            sq_reg[0].sqr  <= '0;

            for (int k = 0; k < SQ_STAGES; k++)
                sq_reg[k+1] <= sqrt_step(sq_reg[k], SQ_STAGES - 1 - k);

            // den = L2 * Lq, split in two partial products
            d1_reg.meta <= sq_reg[SQ_STAGES].meta;
            d1_reg.num  <= sq_reg[SQ_STAGES].num;
            d1_reg.p_lo <= 65'(sq_reg[SQ_STAGES].l2[31:0]) * 65'(sq_reg[SQ_STAGES].root);
            d1_reg.p_hi <= 66'(sq_reg[SQ_STAGES].l2[64:32]) * 66'(sq_reg[SQ_STAGES].root);

            d2_reg.meta <= d1_reg.meta;
            d2_reg.num  <= d1_reg.num;
            d2_reg.den  <= 98'(d1_reg.p_lo) + (98'(d1_reg.p_hi) << 32);

            // quotient of 2^63 or more saturates
            dv_reg[0].meta <= d2_reg.meta;
            dv_reg[0].big  <= 161'(d2_reg.num) >= (161'(d2_reg.den) << DIV_STAGES);
            dv_reg[0].rem  <= d2_reg.num;
            dv_reg[0].quo  <= '0;
            dv_reg[0].den  <= d2_reg.den;

            for (int k = 0; k < DIV_STAGES; k++)
                dv_reg[k+1] <= div_step(dv_reg[k], DIV_STAGES - 1 - k);

            out_status_reg <= dv_reg[DIV_STAGES].meta.status;
            out_last_reg   <= dv_reg[DIV_STAGES].meta.last;
            if (dv_reg[DIV_STAGES].meta.status != ST_OK)
            begin
                out_gidx_reg  <= '0;
                out_stiff_reg <= '0;
            end
            else
            begin
                out_gidx_reg <= dv_reg[DIV_STAGES].meta.gidx;
                priority if (dv_reg[DIV_STAGES].meta.negate && dv_reg[DIV_STAGES].big)
                    out_stiff_reg <= 64'h8000_0000_0000_0000;
                else if (dv_reg[DIV_STAGES].meta.negate)
                    out_stiff_reg <= -(64'(dv_reg[DIV_STAGES].quo));
                else if (dv_reg[DIV_STAGES].big)
                    out_stiff_reg <= 64'h7FFF_FFFF_FFFF_FFFF;
                else
                    out_stiff_reg <= 64'(dv_reg[DIV_STAGES].quo);
            end
        end
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            sqv_reg       <= '0;
            vd1_reg       <= 1'b0;
            vd2_reg       <= 1'b0;
            dvv_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= mbr_valid_reg;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            sqv_reg       <= {sqv_reg[SQ_STAGES-1:0], v3_reg};
            vd1_reg       <= sqv_reg[SQ_STAGES];
            vd2_reg       <= vd1_reg;
            dvv_reg       <= {dvv_reg[DIV_STAGES-1:0], vd2_reg};
            out_valid_reg <= dvv_reg[DIV_STAGES];
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.global_index = out_gidx_reg;
    assign result.stiffness    = out_stiff_reg;
    assign result.status       = out_status_reg;
    assign result.last         = out_last_reg;

    // ---------------- assertions ----------------
`include "truss_member_stiffness_assert.svh"

    `TMS_ASSERT_NOW(a_err_zero, out_valid_reg && out_status_reg != ST_OK, out_stiff_reg == '0 && out_gidx_reg == '0, "error item carries nonzero payload")
    `TMS_ASSERT_NEXT(a_take_restart, take, mbr_valid_reg && cnt_reg == '0, "sequencer did not restart on accept")
    `TMS_ASSERT_NEXT(a_seq_step, mbr_valid_reg && adv && !take && cnt_reg != LAST_ENTRY, mbr_valid_reg && cnt_reg == $past(cnt_reg) + 4'd1, "sequencer skipped an entry")
    `TMS_ASSERT_NEXT(a_hold_on_stall, mbr_valid_reg && !adv, mbr_valid_reg && $stable(cnt_reg), "sequencer moved during stall")

endmodule
